[rtl/wps_pkg.sv]
// Package with the shared types and constants of the pixel serializer.
`timescale 1ns / 1ps
package wps_pkg;

   localparam int CNT_W = 6;

   localparam logic [2:0] CSR_ZERO_HIGH = 3'd0;
   localparam logic [2:0] CSR_ZERO_LOW  = 3'd1;
   localparam logic [2:0] CSR_ONE_HIGH  = 3'd2;
   localparam logic [2:0] CSR_ONE_LOW   = 3'd3;
   localparam logic [2:0] CSR_GAP       = 3'd4;
   localparam logic [2:0] CSR_ORDER     = 3'd5;
   localparam logic [2:0] CSR_RGBW      = 3'd6;

   localparam logic [9:0]  RST_ZERO_HIGH = 10'd5;
   localparam logic [9:0]  RST_ZERO_LOW  = 10'd100;
   localparam logic [9:0]  RST_ONE_HIGH  = 10'd55;
   localparam logic [9:0]  RST_ONE_LOW   = 10'd45;
   localparam logic [15:0] RST_GAP       = 16'd8000;

   localparam logic [CNT_W-1:0] BITS_RGB  = 6'd24;
   localparam logic [CNT_W-1:0] BITS_RGBW = 6'd32;

   typedef struct packed {
      logic [9:0]  zero_high;
      logic [9:0]  zero_low;
      logic [9:0]  one_high;
      logic [9:0]  one_low;
      logic [15:0] gap;
      logic        order_grb;
      logic        rgbw;
   } cfg_type;

   typedef struct packed {
      logic [31:0] bits;
      logic        rgbw;
      logic        last;
   } item_type;

endpackage

[rtl/wps_front.sv]
// Front stage: accepts pixel words and orders their bytes into a bit word.
`timescale 1ns / 1ps
module wps_front (
   input  logic              clock,
   input  logic              reset,
   input  wps_pkg::cfg_type  cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        red,
   input  logic [7:0]        green,
   input  logic [7:0]        blue,
   input  logic              last_pixel,
   output logic              item_valid,
   output wps_pkg::item_type item,
   input  logic              item_stall
);
   import wps_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     accept;

   assign req_stall  = valid_ff && item_stall;
   assign accept     = req_valid && !req_stall;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = accept ? 1'b1 : (item_stall ? valid_ff : 1'b0);
      item_in  = item_ff;
      if (accept) begin
         item_in.bits = cfg.order_grb ? {green, red, blue, 8'h00} : {red, green, blue, 8'h00};
         item_in.rgbw = cfg.rgbw;
         item_in.last = last_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

[rtl/wps_queue.sv]
// Short queue of ordered pixel words between the front and back stages.
`timescale 1ns / 1ps
module wps_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  wps_pkg::item_type push_item,
   output logic              push_stall,
   output logic              pop_valid,
   output wps_pkg::item_type pop_item,
   input  logic              pop_stall
);
   import wps_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_QW = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(DEPTH);

   item_type          slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0] count_ff, count_in;
   logic              push, pop;

   assign push_stall = (count_ff == FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && !push_stall;
   assign pop        = pop_valid && !pop_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[rtl/wps_back.sv]
// Back stage: shifts out one bit segment per cycle while the output is not stalled, and the frame latch gap.
`timescale 1ns / 1ps
module wps_back (
   input  logic              clock,
   input  logic              reset,
   input  wps_pkg::cfg_type  cfg,
   input  logic              item_valid,
   input  wps_pkg::item_type item,
   output logic              item_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [9:0]        rsp_high_ticks,
   output logic [15:0]       rsp_low_ticks,
   output logic              rsp_data_bit,
   output logic              rsp_is_reset_gap,
   output logic              rsp_last_of_run
);
   import wps_pkg::*;

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]      shift_ff, shift_in;
   logic             rgbw_ff, rgbw_in, last_ff, last_in;
   logic             valid_ff, valid_in;
   logic [9:0]       high_ff, high_in;
   logic [15:0]      low_ff, low_in;
   logic             bit_ff, bit_in, gap_ff, gap_in, fin_ff, fin_in;
   logic             adv, emit, load, at_gap, final_seg;
   logic [CNT_W-1:0] nbits;

   assign adv       = !valid_ff || !rsp_stall;
   assign nbits     = rgbw_ff ? BITS_RGBW : BITS_RGB;
   assign at_gap    = (cnt_ff == nbits);
   assign final_seg = last_ff ? at_gap : (cnt_ff == nbits - 1'b1);
   assign emit      = busy_ff && adv;
   assign load      = item_valid && (!busy_ff || (emit && final_seg));
   assign item_stall = !load;

   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rgbw_in  = rgbw_ff;
      last_in  = last_ff;
      valid_in = adv ? 1'b0 : valid_ff;
      high_in  = high_ff;
      low_in   = low_ff;
      bit_in   = bit_ff;
      gap_in   = gap_ff;
      fin_in   = fin_ff;
      if (emit) begin
         valid_in = 1'b1;
         cnt_in   = cnt_ff + 1'b1;
         shift_in = {shift_ff[30:0], 1'b0};
         fin_in   = final_seg;
         if (final_seg) begin
            busy_in = 1'b0;
         end
         if (at_gap) begin
            high_in = '0;
            low_in  = cfg.gap;
            bit_in  = 1'b0;
            gap_in  = 1'b1;
         end else begin
            high_in = shift_ff[31] ? cfg.one_high : cfg.zero_high;
            low_in  = {6'd0, shift_ff[31] ? cfg.one_low : cfg.zero_low};
            bit_in  = shift_ff[31];
            gap_in  = 1'b0;
         end
      end
      if (load) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         shift_in = item.bits;
         rgbw_in  = item.rgbw;
         last_in  = item.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
      cnt_ff   <= cnt_in;
      shift_ff <= shift_in;
      rgbw_ff  <= rgbw_in;
      last_ff  <= last_in;
      high_ff  <= high_in;
      low_ff   <= low_in;
      bit_ff   <= bit_in;
      gap_ff   <= gap_in;
      fin_ff   <= fin_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_high_ticks   = high_ff;
   assign rsp_low_ticks    = low_ff;
   assign rsp_data_bit     = bit_ff;
   assign rsp_is_reset_gap = gap_ff;
   assign rsp_last_of_run  = fin_ff;

endmodule

[rtl/ws2812_pixel_serializer_unit.sv]
// Top level of the single-wire LED pixel serializer with its register file.
//
//   Channel  Direction  Handshake              Word
//   req      in         req_valid / req_stall  red, green, blue, last_pixel
//   rsp      out        rsp_valid / rsp_stall  high/low ticks, bit, gap, last
//   csr      in         csr_write_enable       csr_index, csr_wdata
//
// The back stage emits one segment per cycle while the output is not stalled, so a pixel
// gives 24 segments, 32 in RGBW mode; a frame's last pixel adds one latch gap segment.
// An accepted pixel passes the front register, a queue slot and the back shift register.
// Reset is synchronous; it empties the queue and loads the default timing registers.
// A stalled output holds its word; the front accepts until queue and its register fill.
`timescale 1ns / 1ps
module ws2812_pixel_serializer_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic        req_last_pixel,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [9:0]  rsp_high_ticks,
   output logic [15:0] rsp_low_ticks,
   output logic        rsp_data_bit,
   output logic        rsp_is_reset_gap,
   output logic        rsp_last_of_run,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import wps_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     front_valid, front_stall, q_valid, q_stall;
   item_type front_item, q_item;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_ZERO_HIGH: cfg_in.zero_high = csr_wdata[9:0];
            CSR_ZERO_LOW:  cfg_in.zero_low  = csr_wdata[9:0];
            CSR_ONE_HIGH:  cfg_in.one_high  = csr_wdata[9:0];
            CSR_ONE_LOW:   cfg_in.one_low   = csr_wdata[9:0];
            CSR_GAP:       cfg_in.gap       = csr_wdata;
            CSR_ORDER:     cfg_in.order_grb = csr_wdata[0];
            CSR_RGBW:      cfg_in.rgbw      = csr_wdata[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zero_high <= RST_ZERO_HIGH;
         cfg_ff.zero_low  <= RST_ZERO_LOW;
         cfg_ff.one_high  <= RST_ONE_HIGH;
         cfg_ff.one_low   <= RST_ONE_LOW;
         cfg_ff.gap       <= RST_GAP;
         cfg_ff.order_grb <= 1'b1;
         cfg_ff.rgbw      <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   wps_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .red        (req_red),
      .green      (req_green),
      .blue       (req_blue),
      .last_pixel (req_last_pixel),
      .item_valid (front_valid),
      .item       (front_item),
      .item_stall (front_stall)
   );

   wps_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_item  (front_item),
      .push_stall (front_stall),
      .pop_valid  (q_valid),
      .pop_item   (q_item),
      .pop_stall  (q_stall)
   );

   wps_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .item_valid       (q_valid),
      .item             (q_item),
      .item_stall       (q_stall),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_high_ticks   (rsp_high_ticks),
      .rsp_low_ticks    (rsp_low_ticks),
      .rsp_data_bit     (rsp_data_bit),
      .rsp_is_reset_gap (rsp_is_reset_gap),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   a_gap_word : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_reset_gap |->
         rsp_last_of_run && !rsp_data_bit && rsp_high_ticks == 10'd0)
      else $error("latch gap word is malformed");

   a_one_timing : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_reset_gap && rsp_data_bit |->
         rsp_high_ticks == cfg_ff.one_high)
      else $error("one bit carries wrong high time");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output word valid right after reset");

endmodule

[verif/tb_ws2812_pixel_serializer_unit.sv]
// Self-checking testbench for the pixel serializer: pixels in, predicted bit segments checked.
`timescale 1ns / 1ps
module tb_ws2812_pixel_serializer_unit;
   import wps_pkg::*;

   localparam logic [2:0] CSR_NONE = 3'd7;

   typedef struct packed {
      logic [9:0]  high_ticks;
      logic [15:0] low_ticks;
      logic        data_bit;
      logic        is_reset_gap;
      logic        last_of_run;
   } segment_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_red;
   logic [7:0]  req_green;
   logic [7:0]  req_blue;
   logic        req_last_pixel;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [9:0]  rsp_high_ticks;
   logic [15:0] rsp_low_ticks;
   logic        rsp_data_bit;
   logic        rsp_is_reset_gap;
   logic        rsp_last_of_run;
   logic        csr_write_enable;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   cfg_type     shadow_cfg;
   segment_type pending_segments[$];
   int          error_count = 0;
   int          sender_idle_pct = 33;
   int          receiver_stall_pct = 70;

   ws2812_pixel_serializer_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .req_last_pixel   (req_last_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_high_ticks   (rsp_high_ticks),
      .rsp_low_ticks    (rsp_low_ticks),
      .rsp_data_bit     (rsp_data_bit),
      .rsp_is_reset_gap (rsp_is_reset_gap),
      .rsp_last_of_run  (rsp_last_of_run),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   function automatic void apply_csr(input logic [2:0] idx, input logic [15:0] data);
      case (idx)
         CSR_ZERO_HIGH: shadow_cfg.zero_high = data[9:0];
         CSR_ZERO_LOW:  shadow_cfg.zero_low  = data[9:0];
         CSR_ONE_HIGH:  shadow_cfg.one_high  = data[9:0];
         CSR_ONE_LOW:   shadow_cfg.one_low   = data[9:0];
         CSR_GAP:       shadow_cfg.gap       = data;
         CSR_ORDER:     shadow_cfg.order_grb = data[0];
         CSR_RGBW:      shadow_cfg.rgbw      = data[0];
         default: ;
      endcase
   endfunction

   function automatic void expand_pixel(input logic [7:0] red, input logic [7:0] green,
                                        input logic [7:0] blue, input logic last_pixel);
      logic [31:0] stream;
      int          nbits;
      logic        bit_value;
      segment_type seg;
      stream = {shadow_cfg.order_grb ? green : red, shadow_cfg.order_grb ? red : green,
                blue, 8'h00};
      nbits = shadow_cfg.rgbw ? 32 : 24;
      for (int k = 0; k < nbits; k++) begin
         bit_value = stream[31 - k];
         seg.high_ticks   = bit_value ? shadow_cfg.one_high : shadow_cfg.zero_high;
         seg.low_ticks    = {6'd0, bit_value ? shadow_cfg.one_low : shadow_cfg.zero_low};
         seg.data_bit     = bit_value;
         seg.is_reset_gap = 1'b0;
         seg.last_of_run  = !last_pixel && (k == nbits - 1);
         pending_segments.push_back(seg);
      end
      if (last_pixel) begin
         seg = '{high_ticks: 10'd0, low_ticks: shadow_cfg.gap, data_bit: 1'b0,
                 is_reset_gap: 1'b1, last_of_run: 1'b1};
         pending_segments.push_back(seg);
      end
   endfunction

   always @(posedge clock) begin : check_segment
      segment_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_segments.size() == 0) begin
            $error("unexpected word: high_ticks %0d, low_ticks %0d", rsp_high_ticks,
                   rsp_low_ticks);
            error_count++;
         end else begin
            want = pending_segments.pop_front();
            if (rsp_high_ticks !== want.high_ticks) begin
               $error("high_ticks: expected %0d, got %0d", want.high_ticks, rsp_high_ticks);
               error_count++;
            end
            if (rsp_low_ticks !== want.low_ticks) begin
               $error("low_ticks: expected %0d, got %0d", want.low_ticks, rsp_low_ticks);
               error_count++;
            end
            if (rsp_data_bit !== want.data_bit) begin
               $error("data_bit: expected %0d, got %0d", want.data_bit, rsp_data_bit);
               error_count++;
            end
            if (rsp_is_reset_gap !== want.is_reset_gap) begin
               $error("is_reset_gap: expected %0d, got %0d", want.is_reset_gap,
                      rsp_is_reset_gap);
               error_count++;
            end
            if (rsp_last_of_run !== want.last_of_run) begin
               $error("last_of_run: expected %0d, got %0d", want.last_of_run,
                      rsp_last_of_run);
               error_count++;
            end
         end
      end
   end

   task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue, input logic last_pixel);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_red        <= red;
      req_green      <= green;
      req_blue       <= blue;
      req_last_pixel <= last_pixel;
      do @(posedge clock); while (req_stall);
      expand_pixel(red, green, blue, last_pixel);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_segments.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [15:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= data;
      @(posedge clock);
      apply_csr(idx, data);
   endtask

   task automatic configure(input logic [15:0] zero_high, input logic [15:0] zero_low,
                            input logic [15:0] one_high, input logic [15:0] one_low,
                            input logic [15:0] gap, input logic order_grb,
                            input logic rgbw);
      wait_drained();
      write_csr(CSR_ZERO_HIGH, zero_high);
      write_csr(CSR_ZERO_LOW, zero_low);
      write_csr(CSR_ONE_HIGH, one_high);
      write_csr(CSR_ONE_LOW, one_low);
      write_csr(CSR_GAP, gap);
      write_csr(CSR_ORDER, {15'd0, order_grb});
      write_csr(CSR_RGBW, {15'd0, rgbw});
      csr_write_enable <= 1'b0;
   endtask

   task automatic test_default_pixels();
      send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
      send_pixel(8'hAA, 8'h55, 8'h0F, 1'b0);
      send_pixel(8'h80, 8'h01, 8'hF0, 1'b1);
      send_pixel(8'h12, 8'h34, 8'h56, 1'b1);
   endtask

   task automatic test_color_order();
      configure(16'd5, 16'd100, 16'd55, 16'd45, 16'd8000, 1'b0, 1'b0);
      send_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
      send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
      send_pixel(8'h00, 8'h00, 8'hFF, 1'b1);
      configure(16'd5, 16'd100, 16'd55, 16'd45, 16'd8000, 1'b1, 1'b1);
      send_pixel(8'h01, 8'h80, 8'h7E, 1'b0);
      send_pixel(8'hC3, 8'h3C, 8'h99, 1'b1);
      configure(16'd5, 16'd100, 16'd55, 16'd45, 16'd8000, 1'b0, 1'b1);
      send_pixel(8'h5A, 8'hA5, 8'h00, 1'b1);
   endtask

   task automatic test_timing_extremes();
      configure(16'd1023, 16'd1023, 16'd1023, 16'd1023, 16'hFFFF, 1'b1, 1'b0);
      send_pixel(8'hF0, 8'h0F, 8'hAA, 1'b1);
      configure(16'd1, 16'd1, 16'd1, 16'd1, 16'd0, 1'b1, 1'b0);
      send_pixel(8'h55, 8'hCC, 8'h33, 1'b1);
      configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0);
      send_pixel(8'h81, 8'h18, 8'hE7, 1'b1);
      // Upper bits of wide values must be dropped and the unused index ignored.
      wait_drained();
      write_csr(CSR_ZERO_HIGH, 16'hFC05);
      write_csr(CSR_ZERO_LOW, 16'hFFFF);
      write_csr(CSR_ONE_HIGH, 16'h0437);
      write_csr(CSR_ONE_LOW, 16'h842D);
      write_csr(CSR_ORDER, 16'hFFFE);
      write_csr(CSR_RGBW, 16'h0003);
      write_csr(CSR_NONE, 16'h1234);
      write_csr(CSR_GAP, 16'hFFFF);
      csr_write_enable <= 1'b0;
      send_pixel(8'hC0, 8'h03, 8'h81, 1'b0);
      send_pixel(8'h7F, 8'hFE, 8'h01, 1'b1);
   endtask

   task automatic test_random_traffic();
      int sent;
      int frame_len;
      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct    = (phase == 0) ? 33 : (phase == 1) ? 70 : 0;
         receiver_stall_pct = (phase == 0) ? 70 : (phase == 1) ? 33 : 0;
         for (int half = 0; half < 2; half++) begin
            configure(16'($urandom_range(1023)), 16'($urandom_range(1023)),
                      16'($urandom_range(1023)), 16'($urandom_range(1023)),
                      16'($urandom_range(65535)), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
            sent = 0;
            while (sent < 20) begin
               frame_len = $urandom_range(8, 1);
               for (int j = 0; j < frame_len; j++) begin
                  send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                             8'($urandom_range(255)),
                             (j == frame_len - 1) || ($urandom_range(9) == 0));
                  sent++;
               end
            end
         end
      end
   endtask

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_red          <= 8'd0;
      req_green        <= 8'd0;
      req_blue         <= 8'd0;
      req_last_pixel   <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_ZERO_HIGH;
      csr_wdata        <= 16'd0;
      shadow_cfg = '{zero_high: RST_ZERO_HIGH, zero_low: RST_ZERO_LOW,
                     one_high: RST_ONE_HIGH, one_low: RST_ONE_LOW, gap: RST_GAP,
                     order_grb: 1'b1, rgbw: 1'b0};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_default_pixels();
      test_color_order();
      test_timing_extremes();
      test_random_traffic();
      wait_drained();
      repeat (20) @(posedge clock);
      if (pending_segments.size() != 0) begin
         $error("%0d expected words never arrived", pending_segments.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
